FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Implication: cause at one edge requires effect at the same edge.
`define ASSERT_IMPLY(label, clk, rstn, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cause) |-> (effect)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/gasl_pkg.sv
`default_nettype none

package gasl_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int SPEED_W        = 16;
    localparam int TIME_W         = 21;
    localparam int TIME_FRAC_BITS = 20;
    localparam int PROD_W         = SPEED_W + TIME_W;
    localparam int RAW_W          = PROD_W - TIME_FRAC_BITS;
    localparam int CMP_W          = (RAW_W > ANGLE_BITS) ? RAW_W : ANGLE_BITS;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = (SPEED_W > ANGLE_BITS) ? SPEED_W : ANGLE_BITS;

    localparam logic [CMP_W-1:0] HALF_TURN = CMP_W'(64'd1 << (ANGLE_BITS - 1));

    localparam logic [SPEED_W-1:0] SLEW_SPEED_RESET = SPEED_W'(5461);

    localparam logic [CFG_IDX_W-1:0] REG_SLEW_SPEED   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_YAW_MODE     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_TARGET  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_TARGET = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_YAW_TARGET   = CFG_IDX_W'(4);

    localparam logic YAW_RELATIVE = 1'b0;

    typedef logic [ANGLE_BITS-1:0] angle_t;

    typedef struct packed {
        logic [SPEED_W-1:0] slew_speed;
        logic               yaw_mode;
        angle_t             roll_target;
        angle_t             pitch_target;
        angle_t             yaw_target;
    } cfg_t;

    // step is already clamped to a half turn
    typedef struct packed {
        angle_t step;
        angle_t heading;
    } stp_t;

    // Shortest-arc move of one axis, at most step units.
    function automatic angle_t slew_axis(angle_t cur, angle_t tgt, angle_t step);
        angle_t d;
        angle_t mag;
        angle_t res;
        d = tgt - cur;
        if (d == '0) begin
            res = cur;
        end else if (d[ANGLE_BITS-1]) begin
            // exactly a half turn away also lands here: move negative
            mag = angle_t'(~d + 1'b1);
            if (mag > step) begin
                mag = step;
            end
            res = cur - mag;
        end else begin
            mag = d;
            if (mag > step) begin
                mag = step;
            end
            res = cur + mag;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gimbal_angle_slew_limiter.sv
// Gimbal angle slew limiter.
// Input channel (s_valid/s_ready): one tick per transfer, carrying the
// elapsed time (2^-20 s units) and the vehicle heading as a binary angle.
// Result channel (m_valid/m_ready): one transfer per tick with the updated
// roll, pitch and yaw, each moved toward its target along the shortest arc
// by at most slew_speed * elapsed_time, saturated at a half turn.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// index 0 slew_speed, 1 yaw_mode, 2..4 roll/pitch/yaw targets; other
// indexes are ignored. Write only while no tick is in flight.
// Pipeline: an accepted tick goes through the input register, the step multiply
// register and the axis update, then is presented on the result channel.
// Throughput: one tick per cycle while m_ready is high, set by the single axis
// update stage that feeds the current angles back to itself each cycle.
// Reset (synchronous, aresetn low): angles clear to zero, slew_speed to
// 5461, yaw mode to vehicle-relative, targets to zero, pipeline empties.
// A stalled receiver holds the result; up to two more ticks queue in the
// input and step stages before s_ready drops.
`default_nettype none

module gimbal_angle_slew_limiter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [gasl_pkg::TIME_W-1:0]    s_elapsed_time,
    input  wire logic [gasl_pkg::ANGLE_BITS-1:0] s_vehicle_heading,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [gasl_pkg::ANGLE_BITS-1:0]     m_roll_angle,
    output logic [gasl_pkg::ANGLE_BITS-1:0]     m_pitch_angle,
    output logic [gasl_pkg::ANGLE_BITS-1:0]     m_yaw_angle,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gasl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gasl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gasl_pkg::*;

`include "assert_macros.svh"

    cfg_t cfg;
    stp_t stp;
    logic stp_valid;
    logic in_valid;
    logic out_free;

    gasl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gasl_step_stage u_step (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_elapsed_time    (s_elapsed_time),
        .s_vehicle_heading (s_vehicle_heading),
        .slew_speed        (cfg.slew_speed),
        .out_free          (out_free),
        .in_valid          (in_valid),
        .stp_valid         (stp_valid),
        .stp               (stp)
    );

    gasl_slew_stage u_slew (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .stp_valid     (stp_valid),
        .stp           (stp),
        .cfg           (cfg),
        .out_free      (out_free),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_roll_angle  (m_roll_angle),
        .m_pitch_angle (m_pitch_angle),
        .m_yaw_angle   (m_yaw_angle)
    );

    // input backpressure only when every stage is full and the output stalls
    `ASSERT_IMPLY(a_ready_low_full, aclk, aresetn, !s_ready,
        in_valid && stp_valid && m_valid && !m_ready)
    `ASSERT_IMPLY(a_out_from_step, aclk, aresetn, $rose(m_valid), $past(stp_valid))
    `ASSERT_IMPLY(a_step_from_in, aclk, aresetn, $rose(stp_valid), $past(in_valid))
    `ASSERT_ALWAYS(a_angles_hold, aclk, aresetn,
        $past(!stp_valid) |-> $stable(m_yaw_angle) && $stable(m_roll_angle))

endmodule

`default_nettype wire

FILE: hw/rtl/gasl_cfg.sv
`default_nettype none

module gasl_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [gasl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gasl_pkg::CFG_DATA_W-1:0] cfg_data,
    output gasl_pkg::cfg_t                      cfg
);
    import gasl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SLEW_SPEED:   cfg_next.slew_speed   = cfg_data[SPEED_W-1:0];
                REG_YAW_MODE:     cfg_next.yaw_mode     = cfg_data[0];
                REG_ROLL_TARGET:  cfg_next.roll_target  = cfg_data[ANGLE_BITS-1:0];
                REG_PITCH_TARGET: cfg_next.pitch_target = cfg_data[ANGLE_BITS-1:0];
                REG_YAW_TARGET:   cfg_next.yaw_target   = cfg_data[ANGLE_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slew_speed   <= SLEW_SPEED_RESET;
            cfg_reg.yaw_mode     <= YAW_RELATIVE;
            cfg_reg.roll_target  <= '0;
            cfg_reg.pitch_target <= '0;
            cfg_reg.yaw_target   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gasl_step_stage.sv
`default_nettype none

module gasl_step_stage (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [gasl_pkg::TIME_W-1:0]    s_elapsed_time,
    input  wire logic [gasl_pkg::ANGLE_BITS-1:0] s_vehicle_heading,
    input  wire logic [gasl_pkg::SPEED_W-1:0]   slew_speed,
    input  wire logic                          out_free,
    output logic                               in_valid,
    output logic                               stp_valid,
    output gasl_pkg::stp_t                     stp
);
    import gasl_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [TIME_W-1:0] elapsed_reg;
    angle_t            heading_reg;
    logic              stp_valid_reg;
    logic              stp_valid_next;
    stp_t              stp_reg;
    logic              stp_free;
    logic              in_adv;
    logic [PROD_W-1:0] prod;
    logic [CMP_W-1:0]  step_raw;
    logic [CMP_W-1:0]  step_clamped;

    assign stp_free  = !stp_valid_reg || out_free;
    assign in_adv    = in_valid_reg && stp_free;
    assign s_ready   = !in_valid_reg || stp_free;
    assign in_valid  = in_valid_reg;
    assign stp_valid = stp_valid_reg;
    assign stp       = stp_reg;

    assign prod         = PROD_W'(slew_speed) * PROD_W'(elapsed_reg);
    assign step_raw     = CMP_W'(prod[PROD_W-1:TIME_FRAC_BITS]);
    assign step_clamped = (step_raw > HALF_TURN) ? HALF_TURN : step_raw;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        stp_valid_next = stp_valid_reg;
        if (stp_free) begin
            stp_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            stp_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            stp_valid_reg <= stp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            elapsed_reg <= s_elapsed_time;
            heading_reg <= s_vehicle_heading;
        end
        if (in_adv) begin
            stp_reg.step    <= step_clamped[ANGLE_BITS-1:0];
            stp_reg.heading <= heading_reg;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gasl_slew_stage.sv
`default_nettype none

module gasl_slew_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           stp_valid,
    input  wire gasl_pkg::stp_t stp,
    input  wire gasl_pkg::cfg_t cfg,
    output logic                out_free,
    input  wire logic           m_ready,
    output logic                m_valid,
    output gasl_pkg::angle_t    m_roll_angle,
    output gasl_pkg::angle_t    m_pitch_angle,
    output gasl_pkg::angle_t    m_yaw_angle
);
    import gasl_pkg::*;

    logic   m_valid_reg;
    logic   m_valid_next;
    angle_t roll_reg;
    angle_t pitch_reg;
    angle_t yaw_reg;
    angle_t roll_next;
    angle_t pitch_next;
    angle_t yaw_next;
    angle_t yaw_goal;
    logic   stp_adv;

    assign out_free = !m_valid_reg || m_ready;
    assign stp_adv  = stp_valid && out_free;

    // current angles double as the result register: they change only on a load
    assign m_valid       = m_valid_reg;
    assign m_roll_angle  = roll_reg;
    assign m_pitch_angle = pitch_reg;
    assign m_yaw_angle   = yaw_reg;

    assign yaw_goal = (cfg.yaw_mode == YAW_RELATIVE) ? stp.heading + cfg.yaw_target
                                                     : cfg.yaw_target;

    always_comb begin
        roll_next    = roll_reg;
        pitch_next   = pitch_reg;
        yaw_next     = yaw_reg;
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = stp_valid;
        end
        if (stp_adv) begin
            roll_next  = slew_axis(roll_reg, cfg.roll_target, stp.step);
            pitch_next = slew_axis(pitch_reg, cfg.pitch_target, stp.step);
            yaw_next   = slew_axis(yaw_reg, yaw_goal, stp.step);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            roll_reg    <= '0;
            pitch_reg   <= '0;
            yaw_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            roll_reg    <= roll_next;
            pitch_reg   <= pitch_next;
            yaw_reg     <= yaw_next;
        end
    end

endmodule

`default_nettype wire
